@@ design/lds_pkg.sv @@
// Shared widths, result record and stage control for the distinct-run tracker.
package lds_pkg;

  localparam int SYM_W      = 8;
  localparam int LEN_W      = 17;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 * LEN_W + 1);

  typedef struct packed {
    logic [LEN_W-1:0] window_len;
    logic [LEN_W-1:0] best_len;
    logic             overflow;
  } result_t;

  typedef struct packed {
    logic accept;  // input transfer this cycle, table read issued
    logic fire;    // update stage hands its item to the output register
    logic last;    // item in the update stage closes the string
  } step_ctl_t;

endpackage

@@ design/lds_ram.sv @@
// Last-position table: one write port, one registered read port.
module lds_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write: the caller forwards a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/lds_window.sv @@
// Window update stage: valid bits, forwarding, position, window base and best length.
module lds_window #(
  parameter int MAX_LEN  = 65536,
  parameter int ALPHABET = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lds_pkg::step_ctl_t          ctl,
  input  logic [$clog2(ALPHABET)-1:0] in_addr,
  input  logic [$clog2(ALPHABET)-1:0] s1_addr,
  input  logic [$clog2(MAX_LEN)-1:0]  rd_data,
  output lds_pkg::result_t            res,
  output logic                        wr_en,
  output logic [$clog2(MAX_LEN)-1:0]  wr_data
);
  import lds_pkg::*;

  localparam int PW  = $clog2(MAX_LEN);
  localparam int PCW = $clog2(MAX_LEN + 1);

  logic [ALPHABET-1:0] seen;
  logic [PCW-1:0]      pos;
  logic [PCW-1:0]      base;
  logic [PCW-1:0]      best;
  logic                ovf;
  logic                fwd_hit;
  logic [PW-1:0]       fwd_data;

  logic [PCW-1:0] pos_next;
  logic [PCW-1:0] base_next;
  logic [PCW-1:0] best_next;
  logic           ovf_next;
  logic [PCW-1:0] wlen;
  logic [PCW-1:0] last_pos;
  logic           in_range;
  logic           hit;

  always_comb begin
    last_pos  = PCW'(fwd_hit ? fwd_data : rd_data);
    in_range  = pos < PCW'(MAX_LEN);
    hit       = seen[s1_addr] && (last_pos >= base);
    pos_next  = pos;
    base_next = base;
    best_next = best;
    ovf_next  = ovf;
    if (in_range) begin
      pos_next = pos + PCW'(1);
      if (hit) begin
        base_next = last_pos + PCW'(1);
        wlen      = pos - last_pos;
      end else begin
        wlen      = pos + PCW'(1) - base;
      end
      if (wlen > best) begin
        best_next = wlen;
      end
    end else begin
      ovf_next = 1'b1;
      wlen     = pos - base;
    end
    res.window_len = LEN_W'(wlen);
    res.best_len   = LEN_W'(best_next);
    res.overflow   = ovf_next;
    wr_en          = ctl.fire && in_range;
    wr_data        = pos[PW-1:0];
  end

  // catch the write that lands in the same edge as the next table read
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      fwd_hit  <= wr_en && (s1_addr == in_addr);
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      pos  <= '0;
      base <= '0;
      best <= '0;
      ovf  <= 1'b0;
    end else if (ctl.fire) begin
      if (ctl.last) begin
        seen <= '0;
        pos  <= '0;
        base <= '0;
        best <= '0;
        ovf  <= 1'b0;
      end else begin
        if (wr_en) begin
          seen[s1_addr] <= 1'b1;
        end
        pos  <= pos_next;
        base <= base_next;
        best <= best_next;
        ovf  <= ovf_next;
      end
    end
  end

endmodule

@@ design/longest_distinct_run_length_top.sv @@
// Top level of the longest repeat-free run tracker over a byte stream.
//
//   channel   dir  tdata bits (lowest first)                         tlast
//   s_*       in   symbol[7:0]                                       end_of_string
//   m_*       out  window_len[16:0], best_len[33:17], overflow[34],  is_final
//                  zero fill [39:35]
//
// One byte per cycle sustained while m_tready is high; a result passes through
// the update stage and the output register. The rate is set by the last-position
// table: one read at the input transfer, one write in the update stage, with a
// forward for back-to-back bytes of equal value.
// Synchronous reset clears control, valid bits and counters; the table needs
// no clearing pass, as an entry is only used behind its valid bit.
// With m_tready low the result holds and the input stalls once the update
// stage is full.
module longest_distinct_run_length_top #(
  parameter int MAX_LEN  = 65536,
  parameter int ALPHABET = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [lds_pkg::IN_DATA_W-1:0]      s_tdata,   // symbol
  input  logic                               s_tlast,   // end_of_string
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lds_pkg::OUT_DATA_W-1:0]     m_tdata,   // window_len, best_len, overflow
  output logic                               m_tlast    // is_final
);
  import lds_pkg::*;

  localparam int AW = $clog2(ALPHABET);
  localparam int PW = $clog2(MAX_LEN);

  logic [AW-1:0]  mod_tbl [256];
  logic [AW-1:0]  in_addr;
  logic           s1_valid;
  logic [AW-1:0]  s1_addr;
  logic           s1_last;
  logic           s1_fire;
  logic           accept;
  step_ctl_t      ctl;
  result_t        res;
  logic [PW-1:0]  rd_data;
  logic           wr_en;
  logic [PW-1:0]  wr_data;

  // fold symbols onto the alphabet
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = AW'(g % ALPHABET);
  end

  assign in_addr    = mod_tbl[s_tdata[SYM_W-1:0]];
  assign s1_fire    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_fire;
  assign accept     = s_tvalid && s_tready;
  assign ctl.accept = accept;
  assign ctl.fire   = s1_fire;
  assign ctl.last   = s1_last;

  lds_ram #(
    .DEPTH (ALPHABET),
    .WIDTH (PW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (wr_data)
  );

  lds_window #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .in_addr (in_addr),
    .s1_addr (s1_addr),
    .rd_data (rd_data),
    .res     (res),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  // update stage occupancy: advance on transfer in, drop when handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= in_addr;
      s1_last <= s_tlast;
    end
  end

  // output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, res.overflow, res.best_len, res.window_len};
      m_tlast <= s1_last;
    end
  end

endmodule

@@ design/lds_checker.sv @@
// Port-level checks for the distinct-run tracker, bound to its top level.
module lds_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lds_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import lds_pkg::*;

  logic [1:0] occ;
  logic       ovf_seen;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      ovf_seen <= 1'b0;
    end else begin
      occ <= occ + 2'(in_xfer) - 2'(out_xfer);
      if (out_xfer) begin
        ovf_seen <= m_tdata[2*LEN_W] && !m_tlast;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_depth: assert property (@(posedge clk) disable iff (rst) occ != 2'd3)
    else $error("more than two items in flight");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> occ != 2'd0)
    else $error("result without a transfer in");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    out_xfer && ovf_seen |-> m_tdata[2*LEN_W])
    else $error("overflow dropped within a string");

endmodule

bind longest_distinct_run_length_top lds_checker u_chk (.*);
